>>> hw/rtl/skt_pkg.sv
// skt_pkg: shared types and codes for the sorted key table
// operation codes, item and result beats, controller state and handshake structs
// no dependencies
`timescale 1ns / 1ps

package skt_pkg;

	localparam int KEY_W     = 32;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_DEL_KEY   = 2'd1,
		OP_DEL_SCORE = 2'd2,
		OP_CLEAR     = 2'd3
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [KEY_W-1:0] key;
		logic signed [KEY_W-1:0] score_value;
	} item_t;

	typedef struct packed {
		logic                 success;
		logic [CNT_OUT_W-1:0] removed_count;
		logic [CNT_OUT_W-1:0] entry_count;
		logic                 is_empty;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic finish;
	} ctrl_status_t;

endpackage

>>> hw/rtl/sorted_key_table_top.sv
// sorted_key_table_top: table of key and score pairs kept in ascending key order
// depends on skt_pkg, skt_ctrl, skt_datapath, skt_ram
`timescale 1ns / 1ps

// An operation is accepted when start is high and busy is low. The block then
// walks its key and score memories one entry per cycle through a single read
// and a single write port. Busy stays high until the walk ends. Insert moves
// up each entry whose key is larger than the new key, then writes the new one.
// Delete by key walks every held entry when the key is present. When the key
// is absent, it stops at the first larger key, or walks every held entry if
// there is no larger key. Delete by score walks every held entry. Clear, or
// an insert into a full table, ends on its first scan step. The result beat
// appears on result with done high for exactly one cycle, the first cycle with
// busy low again. It cannot be held off, and the next start may be given in
// that same cycle. The counts on the result are reported modulo 32.
module sorted_key_table_top #(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  skt_pkg::item_t   item,
	output logic             busy,
	output skt_pkg::result_t result,
	output logic             done
);

	import skt_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	skt_datapath #(.CAPACITY(CAPACITY)) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result),
		.done   (done)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result beat not at end of an operation");

	a_fail_removes_none: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.success |-> result.removed_count == '0)
		else $error("failed operation reported removed entries");

endmodule

>>> hw/rtl/skt_ram.sv
// skt_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module skt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/skt_ctrl.sv
// skt_ctrl: sequencer for the sorted key table
// depends on skt_pkg for state and command types
`timescale 1ns / 1ps

module skt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  skt_pkg::ctrl_status_t status,
	output skt_pkg::ctrl_cmd_t    cmd,
	output logic                  busy
);

	import skt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_SCAN: begin
				busy     = 1'b1;
				cmd.step = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

>>> hw/rtl/skt_datapath.sv
// skt_datapath: entry stores, scan counters, compare and result registers
// depends on skt_pkg and skt_ram
`timescale 1ns / 1ps

module skt_datapath #(
	parameter int CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skt_pkg::ctrl_cmd_t    cmd,
	input  skt_pkg::item_t        item,
	output skt_pkg::ctrl_status_t status,
	output skt_pkg::result_t      result,
	output logic                  done
);

	import skt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE = CW'(1);
	localparam logic [CW-1:0] TWO = CW'(2);

	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          fill_d;
	op_t                    op_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] score_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          idx_d;
	logic [CW-1:0]          wr_q;
	logic [CW-1:0]          wr_d;
	logic                   found_q;
	logic                   found_d;
	logic [CW-1:0]          removed_q;
	logic [CW-1:0]          removed_d;
	result_t                result_q;
	logic                   done_q;

	logic                   we;
	logic [CW-1:0]          waddr;
	logic [KEY_W-1:0]       wkey;
	logic [KEY_W-1:0]       wscore;
	logic [CW-1:0]          raddr;
	logic [KEY_W-1:0]       rkey;
	logic [KEY_W-1:0]       rscore;
	logic                   finish;
	logic                   success;
	logic                   drop;
	logic                   key_gt;

	skt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr[AW-1:0]),
		.wdata (wkey),
		.raddr (raddr[AW-1:0]),
		.rdata (rkey)
	);

	skt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_score_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr[AW-1:0]),
		.wdata (wscore),
		.raddr (raddr[AW-1:0]),
		.rdata (rscore)
	);

	assign key_gt = $signed(rkey) > key_q;

	always_comb begin
		fill_d    = fill_q;
		idx_d     = idx_q;
		wr_d      = wr_q;
		found_d   = found_q;
		removed_d = removed_q;
		we        = 1'b0;
		waddr     = idx_q;
		wkey      = rkey;
		wscore    = rscore;
		finish    = 1'b0;
		success   = 1'b0;
		drop      = 1'b0;
		raddr     = '0;

		if (cmd.load) begin
			raddr = (item.op == OP_INSERT) ? (fill_q - ONE) : '0;
		end else if (op_q == OP_INSERT) begin
			raddr = idx_q - TWO;
		end else begin
			raddr = idx_q + ONE;
		end

		if (cmd.step) begin
			unique case (op_q)
				OP_INSERT: begin
					if (fill_q == CAP) begin
						finish = 1'b1;
					end else if (idx_q == '0 || !key_gt) begin
						we      = 1'b1;
						wkey    = key_q;
						wscore  = score_q;
						finish  = 1'b1;
						success = 1'b1;
						fill_d  = fill_q + ONE;
					end else begin
						we    = 1'b1;
						idx_d = idx_q - ONE;
					end
				end
				OP_DEL_KEY, OP_DEL_SCORE: begin
					if (idx_q == fill_q) begin
						finish  = 1'b1;
						fill_d  = wr_q;
						success = removed_q != '0;
					end else if (op_q == OP_DEL_KEY && !found_q && key_gt) begin
						finish = 1'b1;
					end else begin
						if (op_q == OP_DEL_KEY) begin
							drop = !found_q && (rkey == key_q);
						end else begin
							drop = rscore == score_q;
						end
						idx_d = idx_q + ONE;
						if (drop) begin
							found_d   = 1'b1;
							removed_d = removed_q + ONE;
						end else begin
							we    = 1'b1;
							waddr = wr_q;
							wr_d  = wr_q + ONE;
						end
					end
				end
				OP_CLEAR: begin
					finish    = 1'b1;
					success   = 1'b1;
					removed_d = fill_q;
					fill_d    = '0;
				end
				default: finish = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= cmd.step && finish;
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.step) begin
				fill_q  <= fill_d;
				found_q <= found_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= item.op;
			key_q     <= item.key;
			score_q   <= item.score_value;
			idx_q     <= (item.op == OP_INSERT) ? fill_q : '0;
			wr_q      <= '0;
			removed_q <= '0;
		end else if (cmd.step) begin
			idx_q     <= idx_d;
			wr_q      <= wr_d;
			removed_q <= removed_d;
		end
		if (cmd.step && finish) begin
			result_q.success       <= success;
			result_q.removed_count <= CNT_OUT_W'(removed_d);
			result_q.entry_count   <= CNT_OUT_W'(fill_d);
			result_q.is_empty      <= fill_d == '0;
		end
	end

	assign status.finish = finish;
	assign result        = result_q;
	assign done          = done_q;

endmodule

>>> tb/tb_sorted_key_table_top.sv
// tb_sorted_key_table_top: self-checking bench for the sorted key table
// directed rows first, then biased random insert/delete/clear beats, each result
// checked against a fixed expectation or a model of the ordered table; depends on skt_pkg
`timescale 1ns / 1ps

module tb_sorted_key_table_top;
	import skt_pkg::*;

	localparam int CAPACITY     = 16;
	localparam int RANDOM_ITEMS = 1420;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] score;
	} entry_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] key;
		logic signed [31:0] key_step;
		logic signed [31:0] score;
		int                 reps;
		bit                 fixed;
		result_t            want;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	result_t result;
	logic    done;

	entry_t  entries_q[$];
	result_t expected_q[$];
	int      mismatches;
	int      cycles;

	sorted_key_table_top #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.busy  (busy),
		.result(result),
		.done  (done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ordered table model: applies one operation and returns its result
	function automatic result_t apply_table_op(input item_t it);
		result_t r;
		int      pos;
		int      n_removed;
		entry_t  kept[$];
		entry_t  e;
		r = '0;
		n_removed = 0;
		case (it.op)
			OP_INSERT: begin
				if (entries_q.size() < CAPACITY) begin
					pos = 0;
					while (pos < entries_q.size() && entries_q[pos].key <= it.key)
						pos++;
					e.key = it.key;
					e.score = it.score_value;
					entries_q.insert(pos, e);
					r.success = 1'b1;
				end
			end
			OP_DEL_KEY: begin
				for (pos = 0; pos < entries_q.size(); pos++) begin
					if (entries_q[pos].key == it.key) begin
						entries_q.delete(pos);
						r.success = 1'b1;
						n_removed = 1;
						break;
					end
					if (entries_q[pos].key > it.key)
						break;
				end
			end
			OP_DEL_SCORE: begin
				foreach (entries_q[i]) begin
					if (entries_q[i].score == it.score_value)
						n_removed++;
					else
						kept.push_back(entries_q[i]);
				end
				entries_q = kept;
				r.success = (n_removed > 0);
			end
			default: begin
				n_removed = entries_q.size();
				entries_q.delete();
				r.success = 1'b1;
			end
		endcase
		r.removed_count = n_removed[4:0];
		pos = entries_q.size();
		r.entry_count = pos[4:0];
		r.is_empty = (entries_q.size() == 0);
		return r;
	endfunction

	function automatic stim_row_t mk_row(input op_t op, input logic signed [31:0] key,
		input logic signed [31:0] key_step, input logic signed [31:0] score,
		input int reps, input bit fixed, input logic success, input logic [4:0] removed,
		input logic [4:0] count, input logic empty);
		stim_row_t row;
		row.op = op;
		row.key = key;
		row.key_step = key_step;
		row.score = score;
		row.reps = reps;
		row.fixed = fixed;
		row.want.success = success;
		row.want.removed_count = removed;
		row.want.entry_count = count;
		row.want.is_empty = empty;
		return row;
	endfunction

	// mostly small pools so keys and scores collide, sometimes extremes or anything
	function automatic logic signed [31:0] draw_value(input int pool_hi);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return $signed($urandom_range(0, 2 * pool_hi)) - pool_hi;
		else if (sel < 75)
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return -32'sd1;
				default: return 32'sd0;
			endcase
		return $urandom;
	endfunction

	// drive one beat after a gap, wait for acceptance, record its expectation
	task automatic send_beat(input item_t it, input int gap, input bit fixed,
		input result_t want);
		result_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
			@(negedge clk);
		end
		predicted = apply_table_op(it);
		expected_q.push_back(fixed ? want : predicted);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", result);
			end else begin
				if (result.success !== expected_q[0].success
						|| result.removed_count !== expected_q[0].removed_count
						|| result.entry_count !== expected_q[0].entry_count
						|| result.is_empty !== expected_q[0].is_empty) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p",
							expected_q[0], result);
				end
				void'(expected_q.pop_front());
			end
		end
	end

	initial begin
		stim_row_t rows[14];
		item_t     it;
		int        gap;
		int        sel;
		int        phase;
		int        ins_pct;
		bit        no_idle;
		mismatches = 0;
		cycles <= 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;

		rows[0]  = mk_row(OP_DEL_KEY,   0,       0,  0,       1,  1, 0, 0,  0,  1);
		rows[1]  = mk_row(OP_DEL_SCORE, 0,       0,  0,       1,  1, 0, 0,  0,  1);
		rows[2]  = mk_row(OP_CLEAR,     0,       0,  0,       1,  1, 1, 0,  0,  1);
		rows[3]  = mk_row(OP_INSERT,    KEY_MAX, 0,  KEY_MIN, 1,  1, 1, 0,  1,  0);
		rows[4]  = mk_row(OP_INSERT,    KEY_MIN, 0,  KEY_MAX, 1,  1, 1, 0,  2,  0);
		rows[5]  = mk_row(OP_INSERT,    0,       0,  -1,      1,  1, 1, 0,  3,  0);
		rows[6]  = mk_row(OP_INSERT,    0,       0,  5,       1,  0, 0, 0,  0,  0);
		// absent key between present ones stops the scan early
		rows[7]  = mk_row(OP_DEL_KEY,   7,       0,  0,       1,  1, 0, 0,  4,  0);
		rows[8]  = mk_row(OP_DEL_KEY,   0,       0,  0,       1,  0, 0, 0,  0,  0);
		rows[9]  = mk_row(OP_INSERT,    1000,    -77, 9,      13, 0, 0, 0,  0,  0);
		// table full
		rows[10] = mk_row(OP_INSERT,    3,       0,  4,       1,  1, 0, 0,  16, 0);
		rows[11] = mk_row(OP_DEL_SCORE, 0,       0,  9,       1,  1, 1, 13, 3,  0);
		rows[12] = mk_row(OP_DEL_KEY,   KEY_MAX, 0,  0,       1,  0, 0, 0,  0,  0);
		rows[13] = mk_row(OP_CLEAR,     0,       0,  0,       1,  1, 1, 2,  0,  1);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[r]) begin
			for (int n = 0; n < rows[r].reps; n++) begin
				it.op = rows[r].op;
				it.key = rows[r].key + n * rows[r].key_step;
				it.score_value = rows[r].score;
				send_beat(it, $urandom_range(0, 6), rows[r].fixed, rows[r].want);
			end
		end

		no_idle = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			// fill, balanced and drain phases keep the fill level moving end to end
			phase = (n / 120) % 3;
			ins_pct = (phase == 0) ? 70 : (phase == 1) ? 45 : 25;
			sel = $urandom_range(0, 99);
			it.key = draw_value(8);
			it.score_value = draw_value(3);
			if (sel < 3) begin
				it.op = OP_CLEAR;
			end else if (sel < 3 + ins_pct) begin
				it.op = OP_INSERT;
			end else if (sel < 3 + ins_pct + (97 - ins_pct) * 6 / 10) begin
				it.op = OP_DEL_KEY;
				if (entries_q.size() > 0 && $urandom_range(0, 9) < 7)
					it.key = entries_q[$urandom_range(0, entries_q.size() - 1)].key;
			end else begin
				it.op = OP_DEL_SCORE;
				if (entries_q.size() > 0 && $urandom_range(0, 9) < 7)
					it.score_value = entries_q[$urandom_range(0, entries_q.size() - 1)].score;
			end
			gap = no_idle ? 0 : $urandom_range(0, 6);
			send_beat(it, gap, 1'b0, '0);
		end
		start <= 1'b0;

		wait (expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
